### rtl/core/pagb_pkg.sv
package pagb_pkg;

    // averaged value is unsigned 0.16 fixed point; quotient keeps one more bit for saturation
    localparam int AVG_BITS  = 16;
    localparam int QBITS     = AVG_BITS + 1;
    localparam int ROOT_BITS = 8;
    localparam int CHANNELS  = 3;

    // cells: one per quotient bit, one per root bit, then the output register
    localparam int STAGES = QBITS + ROOT_BITS + 1;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-1:0] REG_SAMPLES = 3'd0;

    localparam logic [AVG_BITS-1:0]  SAMPLES_RESET = 16'd1;
    localparam logic [ROOT_BITS-1:0] BYTE_MAX      = 8'd255;

endpackage

### rtl/core/pagb_if.sv
interface pagb_in_if #(
    parameter int SUM_BITS = 32
);
    logic                valid;
    logic                ready;
    logic [SUM_BITS-1:0] red_sum;
    logic [SUM_BITS-1:0] green_sum;
    logic [SUM_BITS-1:0] blue_sum;

    modport source (output valid, output red_sum, output green_sum, output blue_sum,
                    input ready);
    modport sink   (input valid, input red_sum, input green_sum, input blue_sum,
                    output ready);
endinterface

interface pagb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_byte;
    logic [7:0] green_byte;
    logic [7:0] blue_byte;

    modport source (output valid, output red_byte, output green_byte, output blue_byte,
                    input ready);
    modport sink   (input valid, input red_byte, input green_byte, input blue_byte,
                    output ready);
endinterface

### rtl/core/pagb_div_cell.sv
// One restoring-division step: tries divisor << K against the running remainder.
module pagb_div_cell #(
    parameter int SUM_BITS = 32,
    parameter int K        = 0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [pagb_pkg::AVG_BITS-1:0] i_div,
    input  logic [SUM_BITS-1:0]           i_rem,
    input  logic [pagb_pkg::QBITS-1:0]    i_q,
    output logic [SUM_BITS-1:0]           o_rem,
    output logic [pagb_pkg::QBITS-1:0]    o_q
);
    localparam int CW = SUM_BITS + pagb_pkg::AVG_BITS + 1;

    logic [SUM_BITS-1:0]        r_rem, n_rem;
    logic [pagb_pkg::QBITS-1:0] r_q, n_q;
    logic [CW-1:0]              w_rem_x;
    logic [CW-1:0]              w_dk;
    logic [CW-1:0]              w_diff;
    logic                       w_ge;

    always_comb begin
        w_rem_x = CW'(i_rem);
        w_dk    = CW'(i_div) << K;
        w_diff  = w_rem_x - w_dk;
        w_ge    = (w_rem_x >= w_dk);
        n_rem   = w_ge ? w_diff[SUM_BITS-1:0] : i_rem;
        n_q     = i_q;
        n_q[K]  = w_ge;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_rem = r_rem;
    assign o_q   = r_q;
endmodule

### rtl/core/pagb_sqrt_cell.sv
// One bit of the integer square root; the square of the partial root is carried along.
module pagb_sqrt_cell #(
    parameter int S = 0
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [pagb_pkg::AVG_BITS-1:0]  i_v,
    input  logic                           i_sat,
    input  logic [pagb_pkg::ROOT_BITS-1:0] i_r,
    input  logic [pagb_pkg::AVG_BITS-1:0]  i_r2,
    output logic [pagb_pkg::AVG_BITS-1:0]  o_v,
    output logic                           o_sat,
    output logic [pagb_pkg::ROOT_BITS-1:0] o_r,
    output logic [pagb_pkg::AVG_BITS-1:0]  o_r2
);
    localparam int TW = pagb_pkg::AVG_BITS + 1;

    logic [pagb_pkg::AVG_BITS-1:0]  r_v;
    logic                           r_sat;
    logic [pagb_pkg::ROOT_BITS-1:0] r_r, n_r;
    logic [pagb_pkg::AVG_BITS-1:0]  r_r2, n_r2;
    logic [TW-1:0]                  w_t2;
    logic                           w_le;

    // (r + 2^S)^2 = r^2 + r*2^(S+1) + 2^(2S)
    always_comb begin
        w_t2 = TW'(i_r2) + (TW'(i_r) << (S + 1)) + (TW'(1) << (2 * S));
        w_le = (w_t2 <= TW'(i_v));
        n_r  = i_r;
        n_r[S] = w_le;
        n_r2 = w_le ? w_t2[pagb_pkg::AVG_BITS-1:0] : i_r2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v   <= i_v;
            r_sat <= i_sat;
            r_r   <= n_r;
            r_r2  <= n_r2;
        end
    end

    assign o_v   = r_v;
    assign o_sat = r_sat;
    assign o_r   = r_r;
    assign o_r2  = r_r2;
endmodule

### rtl/core/pixel_average_gamma_to_byte.sv
// Pixel average with gamma 2 to bytes.
// i_pix (valid/ready sink) takes one pixel's red, green and blue sums per beat,
// unsigned with 16 fraction bits. o_pix (valid/ready source) gives one beat of
// three bytes per pixel: min(255, floor(sqrt(floor(sum / samples_per_pixel)))).
// samples_per_pixel sits on the APB port at byte address 0 (reset value 1);
// a zero count makes every byte 255. Write it only while the pipe is empty.
// Throughput: one pixel per cycle while o_pix is not stalled. From accept to
// o_pix.valid a beat passes the cell chain: 17 division cells (one quotient
// bit each, the top bit flags an average of 1.0 or more), 8 square-root cells
// (one root bit each) and the output register.
// A stall on o_pix freezes the whole chain; the output register holds the beat
// and i_pix.ready drops only while a finished beat waits, so bubbles still enter.
// Synchronous active-low reset clears the valid chain and sets the count to 1.
module pixel_average_gamma_to_byte #(
    parameter int SUM_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pagb_pkg::APB_AW-1:0]       paddr,
    input  logic [pagb_pkg::APB_DW-1:0]       pwdata,
    output logic [pagb_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    pagb_in_if.sink                           i_pix,
    pagb_out_if.source                        o_pix
);
    localparam int NC = pagb_pkg::CHANNELS;
    localparam int NQ = pagb_pkg::QBITS;
    localparam int NR = pagb_pkg::ROOT_BITS;
    localparam int NS = pagb_pkg::STAGES;

    // config register
    logic [pagb_pkg::AVG_BITS-1:0] r_samples;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples <= pagb_pkg::SAMPLES_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == pagb_pkg::REG_SAMPLES) begin
            r_samples <= pwdata[pagb_pkg::AVG_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == pagb_pkg::REG_SAMPLES)
                  ? pagb_pkg::APB_DW'(r_samples) : '0;

    // valid chain, whole pipe advances together
    logic [NS-1:0] r_vld;
    logic          w_en;

    assign w_en        = !r_vld[NS-1] || o_pix.ready;
    assign i_pix.ready = w_en;
    assign o_pix.valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_pix.valid};
        end
    end

    // per-channel lanes of cells
    logic [SUM_BITS-1:0]           w_sum [NC];
    logic [SUM_BITS-1:0]           w_rem [NC][NQ+1];
    logic [NQ-1:0]                 w_q   [NC][NQ+1];
    logic [pagb_pkg::AVG_BITS-1:0] w_v   [NC][NR+1];
    logic                          w_sat [NC][NR+1];
    logic [NR-1:0]                 w_r   [NC][NR+1];
    logic [pagb_pkg::AVG_BITS-1:0] w_r2  [NC][NR+1];
    logic [NR-1:0]                 r_byte [NC];

    assign w_sum[0] = i_pix.red_sum;
    assign w_sum[1] = i_pix.green_sum;
    assign w_sum[2] = i_pix.blue_sum;

    for (genvar c = 0; c < NC; c++) begin : g_lane
        assign w_rem[c][0] = w_sum[c];
        assign w_q[c][0]   = '0;

        // quotient bits from the saturation bit down to bit 0
        for (genvar j = 0; j < NQ; j++) begin : g_div
            pagb_div_cell #(
                .SUM_BITS (SUM_BITS),
                .K        (NQ - 1 - j)
            ) u_div (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_div (r_samples),
                .i_rem (w_rem[c][j]),
                .i_q   (w_q[c][j]),
                .o_rem (w_rem[c][j+1]),
                .o_q   (w_q[c][j+1])
            );
        end

        assign w_v[c][0]   = w_q[c][NQ][pagb_pkg::AVG_BITS-1:0];
        assign w_sat[c][0] = w_q[c][NQ][NQ-1];
        assign w_r[c][0]   = '0;
        assign w_r2[c][0]  = '0;

        for (genvar j = 0; j < NR; j++) begin : g_sqrt
            pagb_sqrt_cell #(
                .S (NR - 1 - j)
            ) u_sqrt (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_v   (w_v[c][j]),
                .i_sat (w_sat[c][j]),
                .i_r   (w_r[c][j]),
                .i_r2  (w_r2[c][j]),
                .o_v   (w_v[c][j+1]),
                .o_sat (w_sat[c][j+1]),
                .o_r   (w_r[c][j+1]),
                .o_r2  (w_r2[c][j+1])
            );
        end

        // output register: saturate averages of 1.0 or more
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_byte[c] <= w_sat[c][NR] ? pagb_pkg::BYTE_MAX : w_r[c][NR];
            end
        end
    end

    assign o_pix.red_byte   = r_byte[0];
    assign o_pix.green_byte = r_byte[1];
    assign o_pix.blue_byte  = r_byte[2];
endmodule

### dv/gamma_byte_checker.sv
module gamma_byte_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [pagb_pkg::APB_AW-1:0]  paddr,
    input  logic [pagb_pkg::APB_DW-1:0]  pwdata,
    pagb_in_if                           pix_in,
    pagb_out_if                          pix_out,
    output int                           o_errors,
    output int                           o_pending
);
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_bytes;

    logic [pagb_pkg::AVG_BITS-1:0] sample_count;
    t_pixel_bytes                  expected_bytes[$];

    // floor(sqrt(v)), one root bit per pass
    function automatic logic [pagb_pkg::ROOT_BITS-1:0] root_floor(
        logic [pagb_pkg::AVG_BITS-1:0] v
    );
        logic [pagb_pkg::ROOT_BITS-1:0] r;
        logic [pagb_pkg::ROOT_BITS-1:0] t;
        r = '0;
        for (int b = pagb_pkg::ROOT_BITS - 1; b >= 0; b--) begin
            t = r | (pagb_pkg::ROOT_BITS'(1) << b);
            if (int'(t) * int'(t) <= int'(v))
                r = t;
        end
        return r;
    endfunction

    function automatic logic [7:0] gamma_byte(logic [31:0] sum,
                                              logic [pagb_pkg::AVG_BITS-1:0] div);
        logic [31:0] avg;
        if (div == '0)
            return pagb_pkg::BYTE_MAX;  // zero divisor: all-ones quotient
        avg = sum / {16'd0, div};
        if (avg >= 32'h0001_0000)
            return pagb_pkg::BYTE_MAX;  // average of 1.0 or more
        return root_floor(avg[pagb_pkg::AVG_BITS-1:0]);
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_errors++;
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_pixel_bytes want;
        if (!i_rst_n) begin
            sample_count = pagb_pkg::SAMPLES_RESET;
            expected_bytes.delete();
        end else begin
            if (pix_in.valid && pix_in.ready) begin
                want.red   = gamma_byte(pix_in.red_sum, sample_count);
                want.green = gamma_byte(pix_in.green_sum, sample_count);
                want.blue  = gamma_byte(pix_in.blue_sum, sample_count);
                expected_bytes.push_back(want);
            end
            // count takes effect for beats after this edge
            if (psel && penable && pwrite && pready && paddr == pagb_pkg::REG_SAMPLES)
                sample_count = pwdata[pagb_pkg::AVG_BITS-1:0];
            if (pix_out.valid && pix_out.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("pixel beat with nothing expected: %0d %0d %0d",
                           pix_out.red_byte, pix_out.green_byte, pix_out.blue_byte);
                    o_errors++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("red_byte", want.red, pix_out.red_byte);
                    check_field("green_byte", want.green, pix_out.green_byte);
                    check_field("blue_byte", want.blue, pix_out.blue_byte);
                end
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

### dv/tb_pixel_average_gamma_to_byte.sv
module tb_pixel_average_gamma_to_byte;

    // run limit in cycles, far beyond the slowest legal run
    localparam int CYCLE_LIMIT  = 400000;
    // drain margin past the pipe depth
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_BEATS  = 124;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [pagb_pkg::APB_AW-1:0] paddr;
    logic [pagb_pkg::APB_DW-1:0] pwdata;
    logic [pagb_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    int errors;
    int pending;
    int cycles;
    int rx_mode;      // 0: always ready, 1: coin flip, 2: long stalls
    int stall_left;

    pagb_in_if #(.SUM_BITS(32)) pix_in ();
    pagb_out_if                 pix_out ();

    pixel_average_gamma_to_byte #(
        .SUM_BITS (32)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    gamma_byte_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pix_in    (pix_in),
        .pix_out   (pix_out),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: a hung pipe or a lost beat ends here
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_pixel_average_gamma_to_byte: done, errors");
            $finish;
        end
    end

    // Receiver back-pressure. One assignment per falling edge; the stall pattern
    // follows rx_mode, which the stimulus changes from phase to phase.
    always @(negedge i_clk) begin
        logic rdy;
        rdy = 1'b1;
        case (rx_mode)
            1: begin
                rdy = 1'($urandom_range(0, 1));
            end
            2: begin
                if (stall_left > 0) begin
                    rdy = 1'b0;
                    stall_left--;
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = $urandom_range(1, 20);
                end
            end
            default: rdy = 1'b1;
        endcase
        pix_out.ready <= rdy;
    end

    // APB write: setup cycle, then access; register lands on the access edge.
    // Called at a falling edge, returns at one.
    task automatic write_samples(logic [15:0] count);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= pagb_pkg::REG_SAMPLES;
        pwdata  <= {16'd0, count};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drive one pixel beat and hold it until accepted. Called at a falling
    // edge, returns at the falling edge after the accept.
    task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
        pix_in.valid     <= 1'b1;
        pix_in.red_sum   <= r;
        pix_in.green_sum <= g;
        pix_in.blue_sum  <= b;
        do
            @(posedge i_clk);
        while (!pix_in.ready);
        @(negedge i_clk);
    endtask

    // Wait until every expected beat is out, plus the pipe depth, so the
    // count can be changed safely.
    task automatic drain();
        pix_in.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Sum that lands where the math is interesting for this divisor:
    // mostly averages below 1.0, some on perfect-square edges, the 1.0
    // boundary, raw random and the range ends.
    function automatic logic [31:0] shaped_sum(logic [15:0] div);
        logic [63:0] avg;
        logic [63:0] rem;
        logic [63:0] s;
        int          pick;
        int          k;
        pick = $urandom_range(0, 9);
        rem  = (div == 0) ? 64'd0 : 64'($urandom_range(0, int'(div) - 1));
        if (pick < 5) begin
            avg = 64'($urandom_range(0, 65535));
        end else if (pick == 5) begin
            k   = $urandom_range(1, 256);
            avg = 64'(k * k - $urandom_range(0, 1));
        end else if (pick == 6) begin
            avg = 64'($urandom_range(65534, 65537));
        end else if (pick < 9) begin
            return $urandom;
        end else begin
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end
        s = avg * {48'd0, div} + rem;
        return s[31:0];  // wraps like the sum register would
    endfunction

    initial begin
        int          phase_div[15];
        logic [15:0] div;
        int          sent;
        int          burst;
        int          gap;
        int          no_gaps;

        phase_div = '{1, 0, 65535, 2, 3, 7, 100, 255, 256, 1000, 4096, 65534, -1, -1, 1};

        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        pix_in.valid     = 1'b0;
        pix_in.red_sum   = '0;
        pix_in.green_sum = '0;
        pix_in.blue_sum  = '0;
        pix_out.ready    = 1'b0;
        rx_mode          = 0;
        stall_left       = 0;
        cycles           = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, on the reset count of 1: zero, full scale, the 1.0
        // boundary, the largest perfect square and its neighbors.
        send_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(32'd65535, 32'd65536, 32'd65025);
        send_pixel(32'd65024, 32'd1, 32'd3);
        send_pixel(32'd4, 32'd8, 32'd9);
        send_pixel(32'h8000_0000, 32'h0000_FFFF, 32'h0001_0000);
        send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_AAAA);
        drain();

        // largest count: averages straddling 1.0 at the top of the sum range
        write_samples(16'hFFFF);
        send_pixel(32'hFFFF_FFFF, 32'hFFFE_0001, 32'hFFFE_0000);
        send_pixel(32'd65534, 32'd0, 32'd65535);
        send_pixel(32'd65535 * 32'd65025, 32'd65535 * 32'd65024, 32'hFFFE_FFFF);
        drain();

        // zero count: every byte saturates, zero sums included
        write_samples(16'd0);
        send_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_pixel(32'hFFFF_FFFF, 32'd1, 32'd12345);
        drain();

        // small count of 2 with exact and off-by-one multiples
        write_samples(16'd2);
        send_pixel(32'd131071, 32'd131072, 32'd130050);
        send_pixel(32'd130049, 32'd1, 32'hFFFF_FFFF);
        drain();

        // Random phases: each picks a count, a back-pressure pattern and a
        // gap style, then streams bursts of shaped sums.
        foreach (phase_div[p]) begin
            div     = (phase_div[p] < 0) ? 16'($urandom_range(1, 65535)) : 16'(phase_div[p]);
            rx_mode = p % 3;
            no_gaps = (p % 4 == 0);
            write_samples(div);
            sent = 0;
            while (sent < PHASE_BEATS) begin
                burst = $urandom_range(1, 32);
                for (int i = 0; i < burst && sent < PHASE_BEATS; i++) begin
                    send_pixel(shaped_sum(div), shaped_sum(div), shaped_sum(div));
                    sent++;
                end
                gap = no_gaps ? 0 : $urandom_range(0, 6);
                if (gap > 0) begin
                    pix_in.valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            drain();
        end

        // leave the count back at its reset value
        write_samples(pagb_pkg::SAMPLES_RESET);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0)
            $display("tb_pixel_average_gamma_to_byte: done, clean");
        else
            $display("tb_pixel_average_gamma_to_byte: done, errors");
        $finish;
    end

endmodule
